/* hdl/lruk_pkg.sv */
// Shared types and default sizes for the recent key list.
package lruk_pkg;

  // Default list depth and key width
  localparam int DEPTH_DEF     = 3;
  localparam int KEY_WIDTH_DEF = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the input key and update the list this cycle
    logic load;    // load one list entry into the output register
    logic last;    // entry being loaded closes the listing
  } lruk_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a new beat this cycle
  } lruk_stat_t;

endpackage

/* hdl/lruk_ctrl.sv */
// Controller for the recent key list: accept gating and listing sequencer.
module lruk_ctrl import lruk_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lruk_stat_t        stat,
  input  logic [FILL_W-1:0] fill,
  output lruk_cmd_t         cmd,
  output logic [POS_W-1:0]  idx
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state;
  logic   is_last;
  logic   take_ok;

  // Entry at idx is the final one of the current list
  assign is_last = (fill == (FILL_W'(idx) + FILL_W'(1)));

  // A new key is taken when idle, or as the final entry leaves for the output
  always_comb begin
    take_ok    = (state == ST_IDLE) ||
                 ((state == ST_EMIT) && stat.out_free && is_last);
    in_stall   = !take_ok;
    cmd.accept = in_valid && take_ok;
    cmd.load   = (state == ST_EMIT) && stat.out_free;
    cmd.last   = is_last;
  end

  // State and entry index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept) begin
            state <= ST_EMIT;
            idx   <= '0;
          end
        end
        ST_EMIT: begin
          if (cmd.load) begin
            if (is_last) begin
              idx   <= '0;
              state <= cmd.accept ? ST_EMIT : ST_IDLE;
            end else begin
              idx <= idx + POS_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          idx   <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/lruk_dpath.sv */
// Datapath for the recent key list: entry registers, match/shift update, output register.
module lruk_dpath import lruk_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int POS_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int FILL_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [KEY_WIDTH-1:0] key,
  input  lruk_cmd_t            cmd,
  input  logic [POS_W-1:0]     idx,
  output lruk_stat_t           stat,
  output logic [FILL_W-1:0]    fill,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_WIDTH-1:0] entry_key,
  output logic [POS_W-1:0]     position,
  output logic                 last
);

  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic [FILL_W-1:0]    fill_next;
  logic [POS_W-1:0]     hit_idx;
  logic                 found;
  logic                 full;
  logic [POS_W-1:0]     limit;

  assign full          = (fill == FILL_W'(DEPTH));
  assign stat.out_free = !out_valid || !out_stall;

  // Look up the key among the valid entries; lowest position wins
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((FILL_W'(i) < fill) && (keys[i] == key)) begin
        found   = 1'b1;
        hit_idx = POS_W'(i);
      end
    end
  end

  // Entries below limit move back one place; the rest stay put
  always_comb begin
    if (found) begin
      limit     = hit_idx;
      fill_next = fill;
    end else if (full) begin
      limit     = POS_W'(DEPTH - 1);
      fill_next = fill;
    end else begin
      limit     = POS_W'(fill);
      fill_next = fill + FILL_W'(1);
    end
  end

  // Entry registers, no reset: only entries below fill are ever read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      keys[0] <= key;
      for (int i = 1; i < DEPTH; i++) begin
        if (POS_W'(i) <= limit) begin
          keys[i] <= keys[i - 1];
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.accept) begin
      fill <= fill_next;
    end
  end

  // Output register: holds a beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_key <= keys[idx];
      position  <= idx;
      last      <= cmd.last;
    end
  end

endmodule

/* hdl/lru_recent_key_list.sv */
// Top level of the most-recently-used key list.
// Keeps up to DEPTH keys, most recent first. Each accepted key is moved to (or
// inserted at) the front, evicting the oldest entry when the list is full, and
// the whole list is then sent out front to back, one beat per entry, the final
// beat marked by last. A key is taken when the block is idle or in the same
// cycle as the final beat of the previous listing enters the output register,
// so the next key waits until the listing of n entries, where n (1 to DEPTH) is
// the list length after it, is all loaded; the rate is set by the single output
// register, one entry per cycle while downstream does not stall. A downstream
// stall holds the listing and the input stalls with it.
module lru_recent_key_list import lruk_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int POS_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_WIDTH-1:0] key,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_WIDTH-1:0] entry_key,
  output logic [POS_W-1:0]     position,
  output logic                 last
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  lruk_cmd_t         cmd;
  lruk_stat_t        stat;
  logic [FILL_W-1:0] fill;
  logic [POS_W-1:0]  idx;

  lruk_ctrl #(
    .DEPTH  (DEPTH),
    .POS_W  (POS_W),
    .FILL_W (FILL_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .fill     (fill),
    .cmd      (cmd),
    .idx      (idx)
  );

  lruk_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .POS_W     (POS_W),
    .FILL_W    (FILL_W)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .fill      (fill),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .entry_key (entry_key),
    .position  (position),
    .last      (last)
  );

endmodule

/* dv/tb_lru_recent_key_list.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the recent key list: directed, random and back-pressure runs.
module tb_lru_recent_key_list;
  import lruk_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEF;
  localparam int KEY_W         = KEY_WIDTH_DEF;
  localparam int POS_W         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int MAX_GAP       = 9;
  localparam int LONG_HOLD     = 120;
  localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 4;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int MAX_REPORTS   = 10;

  // One beat of a listing
  typedef struct packed {
    logic [KEY_W-1:0] entry_key;
    logic [POS_W-1:0] position;
    logic             last;
  } listing_beat_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] key       = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] entry_key;
  logic [POS_W-1:0] position;
  logic             last;

  // Mirror of the list contents, front first
  logic [KEY_W-1:0] mru_keys [LIST_DEPTH];
  int               mru_fill = 0;

  listing_beat_t    listing_q [$];

  int max_in_gap     = MAX_GAP;
  int max_out_gap    = MAX_GAP;
  int hold_req       = 0;
  int mismatch_count = 0;
  int beats_checked  = 0;
  int keys_sent      = 0;
  int hit_count      = 0;
  int evict_count    = 0;
  int cycle_count    = 0;

  lru_recent_key_list #(
    .DEPTH    (LIST_DEPTH),
    .KEY_WIDTH(KEY_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .key      (key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .entry_key(entry_key),
    .position (position),
    .last     (last)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count, listing_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Move-to-front update and the listing it produces
  function automatic void predict_listing(input logic [KEY_W-1:0] k);
    int            n;
    int            hit;
    int            i;
    listing_beat_t b;
    n   = mru_fill;
    hit = n;
    for (i = 0; i < n; i++) begin
      if (hit == n && mru_keys[i] == k) hit = i;
    end
    // drop the matching entry
    if (hit < n) begin
      for (i = hit; i + 1 < n; i++) mru_keys[i] = mru_keys[i + 1];
      n--;
      hit_count++;
    end
    // list full: oldest falls off the back
    if (n >= LIST_DEPTH) begin
      n = LIST_DEPTH - 1;
      evict_count++;
    end
    for (i = n; i > 0; i--) mru_keys[i] = mru_keys[i - 1];
    mru_keys[0] = k;
    n++;
    mru_fill = n;
    for (i = 0; i < n; i++) begin
      b.entry_key = mru_keys[i];
      b.position  = POS_W'(i);
      b.last      = (i + 1 == n);
      listing_q   = {listing_q, b};
    end
  endfunction

  // Offer one key after a random gap and wait for it to be taken
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_listing(k);
    keys_sent++;
  endtask

  // Sender pauses until every listing beat has arrived
  task automatic wait_listings_done;
    in_valid <= 1'b0;
    while (listing_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Draw a key: mostly from a small pool or the current list, so hits are frequent
  function automatic logic [KEY_W-1:0] pick_key;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return KEY_W'($urandom_range(0, 4) * 16'h1111);
    if (r < 8 && mru_fill > 0) return mru_keys[$urandom_range(0, mru_fill - 1)];
    return KEY_W'($urandom);
  endfunction

  task automatic test_directed;
    logic [KEY_W-1:0] seq [18];
    seq = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hA5A5,
            16'h5A5A, 16'h0000, 16'hA5A5, 16'hA5A5, 16'hFFFF, 16'h0001,
            16'h8000, 16'h0001, 16'h7FFF, 16'h8000, 16'h1234, 16'h1234};
    foreach (seq[i]) send_key(seq[i]);
    wait_listings_done();
  endtask

  task automatic test_random;
    repeat (200) send_key(pick_key());
    wait_listings_done();
  endtask

  // Output held off for a long stretch while keys keep coming
  task automatic test_backpressure;
    max_in_gap = 0;
    hold_req   = LONG_HOLD;
    repeat (12) send_key(pick_key());
    max_in_gap = MAX_GAP;
    wait_listings_done();
  endtask

  // Back-to-back on both sides
  task automatic test_full_rate;
    max_in_gap  = 0;
    max_out_gap = 0;
    repeat (40) send_key(pick_key());
    wait_listings_done();
    max_in_gap  = MAX_GAP;
    max_out_gap = MAX_GAP;
  endtask

  // Receiver: random stall before each beat, or a long hold when asked
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n        = hold_req;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, max_out_gap);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Compare each accepted beat with the oldest expected one
  always @(posedge clk) begin
    listing_beat_t exp_beat;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (listing_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("Unexpected beat: key=%h pos=%0d last=%b", entry_key, position, last);
        mismatch_count++;
      end else begin
        exp_beat = listing_q.pop_front();
        beats_checked++;
        if (entry_key !== exp_beat.entry_key || position !== exp_beat.position ||
            last !== exp_beat.last) begin
          if (mismatch_count < MAX_REPORTS)
            $display("Beat mismatch: expected key=%h pos=%0d last=%b, got key=%h pos=%0d last=%b",
                     exp_beat.entry_key, exp_beat.position, exp_beat.last,
                     entry_key, position, last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    if (listing_q.size() != 0) mismatch_count++;
    $display("Sent %0d keys (%0d hits, %0d evictions), checked %0d listing beats,",
             keys_sent, hit_count, evict_count, beats_checked);
    $display("with random idling, a long output hold-off and a back-to-back stretch.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lruk_pkg.sv
hdl/lruk_ctrl.sv
hdl/lruk_dpath.sv
hdl/lru_recent_key_list.sv
dv/tb_lru_recent_key_list.sv
